FILE: hw/rtl/sitda_pkg.sv
// Shared constants, types and sizing for the signed-to-decimal text converter.
`default_nettype none
package sitda_pkg;

	localparam int VALUE_BITS = 32;

	// Double dabble retires this many magnitude bits per cycle.
	localparam int STEP_BITS   = 4;
	localparam int PAD_BITS    = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int CONV_CYCLES = PAD_BITS / STEP_BITS;
	localparam int CNT_W       = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;

	// Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
	function automatic int dec_digits(input int bits);
		longint unsigned x;
		int d;
		begin
			x = longint'(64'd1 << (bits - 1));
			d = 1;
			for (int i = 0; i < 20; i++) begin
				if (x >= 64'd10) begin
					x = x / 64'd10;
					d++;
				end
			end
			return d;
		end
	endfunction

	localparam int DIGITS = dec_digits(VALUE_BITS);
	localparam int BCD_W  = DIGITS * 4;
	localparam int IDX_W  = $clog2(DIGITS);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;

	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [BCD_W-1:0] bcd;
		logic [IDX_W-1:0] top;
	} conv_t;

endpackage
`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII converter. Each accepted value leaves as a
// run of 1 to 11 character beats ('-' first for a negative number, then the
// digits most significant first, no leading zeros, last flagged on the final
// digit); the most negative value prints as -2147483648. The input is
// classified and held in a two-entry queue, a double dabble unit turns 4 bits
// per cycle into BCD and can convert the next number while the emitter still
// prints the previous one, and the emitter drives one character per cycle
// through an output register unless the output stalls; the input keeps
// accepting while the queue has room, also while a character beat is stalled
// on the output.
`default_nettype none
module signed_int_to_decimal_ascii_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic signed [sitda_pkg::VALUE_BITS-1:0] value,
	input  wire logic                                    item_valid,
	output logic                                         item_ready,
	output logic [7:0]                                   character,
	output logic                                         last,
	output logic                                         char_valid,
	input  wire logic                                    char_ready
);

	sitda_pkg::item_t q_item;
	sitda_pkg::conv_t cv;
	logic             q_valid;
	logic             pop;
	logic             take;

	sitda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.pop        (pop),
		.q_item     (q_item),
		.q_valid    (q_valid)
	);

	sitda_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.pop     (pop),
		.take    (take),
		.cv      (cv)
	);

	sitda_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cv         (cv),
		.take       (take),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/sitda_front.sv
// Front end: takes input beats, splits sign and magnitude, queues them.
`default_nettype none
module sitda_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [sitda_pkg::VALUE_BITS-1:0] value,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire logic                                pop,
	output sitda_pkg::item_t                         q_item,
	output logic                                     q_valid
);

	sitda_pkg::item_t                    mem_q [sitda_pkg::QDEPTH];
	logic [sitda_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [sitda_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [sitda_pkg::QCNT_W-1:0]        cnt_q;
	logic [sitda_pkg::VALUE_BITS-1:0]    raw;
	sitda_pkg::item_t                    cls;
	logic                                push;

	always_comb begin
		raw     = $unsigned(value);
		cls.neg = raw[sitda_pkg::VALUE_BITS-1];
		cls.mag = cls.neg ? (~raw + 1'b1) : raw;
	end

	assign item_ready = (cnt_q != sitda_pkg::QCNT_W'(sitda_pkg::QDEPTH));
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != '0);
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sitda_conv.sv
// Back end, part one: iterative double dabble from magnitude to BCD digits.
`default_nettype none
module sitda_conv (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sitda_pkg::item_t q_item,
	input  wire logic             q_valid,
	output logic                  pop,
	input  wire logic             take,
	output sitda_pkg::conv_t      cv
);

	logic                                   busy_q;
	logic                                   done_q;
	logic [sitda_pkg::CNT_W-1:0]            cnt_q;
	logic                                   neg_q;
	logic [sitda_pkg::PAD_BITS-1:0]         mag_q;
	logic [sitda_pkg::BCD_W-1:0]            bcd_q;
	logic [sitda_pkg::BCD_W+sitda_pkg::PAD_BITS-1:0] sh;
	logic [sitda_pkg::IDX_W-1:0]            top;
	logic                                   finish;

	// Four add-3-then-shift steps per cycle; digits adjust independently.
	always_comb begin
		sh = {bcd_q, mag_q};
		for (int s = 0; s < sitda_pkg::STEP_BITS; s++) begin
			for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
				if (sh[sitda_pkg::PAD_BITS + d*4 +: 4] >= 4'd5) begin
					sh[sitda_pkg::PAD_BITS + d*4 +: 4] =
						sh[sitda_pkg::PAD_BITS + d*4 +: 4] + 4'd3;
				end
			end
			sh = sh << 1;
		end
	end

	// Index of the most significant nonzero digit, zero for a zero value.
	always_comb begin
		top = '0;
		for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				top = sitda_pkg::IDX_W'(d);
			end
		end
	end

	assign finish = busy_q && (cnt_q == sitda_pkg::CNT_W'(sitda_pkg::CONV_CYCLES - 1));
	assign pop    = q_valid && !busy_q && (!done_q || take);

	always_comb begin
		cv.valid = done_q;
		cv.neg   = neg_q;
		cv.bcd   = bcd_q;
		cv.top   = top;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q <= q_item.neg;
			mag_q <= sitda_pkg::PAD_BITS'(q_item.mag);
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= sh[sitda_pkg::PAD_BITS-1:0];
			bcd_q <= sh[sitda_pkg::BCD_W+sitda_pkg::PAD_BITS-1:sitda_pkg::PAD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					done_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sitda_emit.sv
// Back end, part two: walks the BCD digits and drives one character per beat.
`default_nettype none
module sitda_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sitda_pkg::conv_t cv,
	output logic                  take,
	output logic [7:0]            character,
	output logic                  last,
	output logic                  char_valid,
	input  wire logic             char_ready
);

	logic                           busy_q;
	logic                           neg_q;
	logic [sitda_pkg::IDX_W-1:0]    idx_q;
	logic [sitda_pkg::BCD_W-1:0]    bcd_q;
	logic [7:0]                     char_q;
	logic                           last_q;
	logic                           valid_q;
	logic                           adv;
	logic                           fire;
	logic                           final_char;
	logic [3:0]                     digit;

	assign adv        = !valid_q || char_ready;
	assign fire       = busy_q && adv;
	assign final_char = fire && !neg_q && (idx_q == '0);
	assign take       = cv.valid && (!busy_q || final_char);
	assign digit      = bcd_q[idx_q*4 +: 4];

	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q <= neg_q ? sitda_pkg::CH_MINUS : (sitda_pkg::CH_ZERO + {4'd0, digit});
			last_q <= !neg_q && (idx_q == '0);
		end
		if (take) begin
			bcd_q <= cv.bcd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			neg_q   <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
			end else if (adv) begin
				valid_q <= 1'b0;
			end
			if (take) begin
				busy_q <= 1'b1;
				neg_q  <= cv.neg;
				idx_q  <= cv.top;
			end else if (fire) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sitda_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module sitda_checker (
	input wire logic                                    clk,
	input wire logic                                    arst_n,
	input wire logic signed [sitda_pkg::VALUE_BITS-1:0] value,
	input wire logic                                    item_valid,
	input wire logic                                    item_ready,
	input wire logic [7:0]                              character,
	input wire logic                                    last,
	input wire logic                                    char_valid,
	input wire logic                                    char_ready
);

	logic first_q;
	logic is_digit;

	assign is_digit = (character >= sitda_pkg::CH_ZERO) &&
		(character <= sitda_pkg::CH_ZERO + 8'd9);

	// Next output beat opens a new run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (char_valid && char_ready) begin
			first_q <= last;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(value))
		else $error("input beat changed while waiting");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(character) && $stable(last))
		else $error("output beat changed while stalled");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> is_digit || (character == sitda_pkg::CH_MINUS && !last))
		else $error("bad character or flagged minus");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !first_q |-> character != sitda_pkg::CH_MINUS)
		else $error("minus sign inside a run");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && first_q && character == sitda_pkg::CH_ZERO |-> last)
		else $error("leading zero not suppressed");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.value      (value),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.character  (character),
	.last       (last),
	.char_valid (char_valid),
	.char_ready (char_ready)
);
`default_nettype wire

FILE: tb/sv/tb_signed_int_to_decimal_ascii_unit.sv
// Testbench for the signed integer to decimal ASCII converter: directed and random values.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

	localparam int RADIX        = 10;
	localparam int DIR_ROWS     = 22;
	localparam int RANDOM_ITEMS = 88;
	localparam int PRESSURE_AT  = DIR_ROWS + 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_beat_t;

	logic                                    clk        = 1'b0;
	logic                                    arst_n     = 1'b0;
	logic signed [sitda_pkg::VALUE_BITS-1:0] value      = '0;
	logic                                    item_valid = 1'b0;
	logic                                    item_ready;
	logic [7:0]                              character;
	logic                                    last;
	logic                                    char_valid;
	logic                                    char_ready = 1'b0;

	char_beat_t pending_chars[$];
	int         failures       = 0;
	int         items_accepted = 0;
	int         chars_checked  = 0;
	int         negatives      = 0;
	int         longest_run    = 0;
	int         run_len        = 0;
	int         cycles         = 0;
	int         hold_left      = 0;
	bit         hold_done      = 1'b0;

	logic signed [sitda_pkg::VALUE_BITS-1:0] dir_value [DIR_ROWS] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd2147483647, 32'h8000_0000,
		32'sd1000000000, -32'sd1000000000, 32'sd999999999, -32'sd2147483647, 32'sd100,
		-32'sd99, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd12345, -32'sd98765, 32'sd4294967,
		-32'sd7, 32'sd0, 32'h7FFF_0000
	};
	// empty text: expectation comes from the predictor
	string dir_text [DIR_ROWS] = '{
		"0", "1", "-1", "9", "10", "-10", "2147483647", "-2147483648",
		"1000000000", "-1000000000", "999999999", "-2147483647", "100",
		"-99", "", "", "", "", "", "-7", "0", ""
	};

	signed_int_to_decimal_ascii_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Decimal text of one value: optional minus, digits most significant first.
	function automatic void predict_decimal(input logic signed [sitda_pkg::VALUE_BITS-1:0] v);
		logic [sitda_pkg::VALUE_BITS-1:0] mag;
		logic [3:0]                       digs[$];
		char_beat_t                       beat;
		mag = v[sitda_pkg::VALUE_BITS-1] ? (~v + 1'b1) : v;
		if (v[sitda_pkg::VALUE_BITS-1]) begin
			beat.ch  = sitda_pkg::CH_MINUS;
			beat.fin = 1'b0;
			pending_chars.push_back(beat);
		end
		do begin
			digs.push_front(4'(mag % RADIX));
			mag = mag / RADIX;
		end while (mag != 0);
		foreach (digs[i]) begin
			beat.ch  = sitda_pkg::CH_ZERO + 8'(digs[i]);
			beat.fin = (i == digs.size() - 1);
			pending_chars.push_back(beat);
		end
	endfunction

	function automatic void expect_text(input string s);
		char_beat_t beat;
		for (int i = 0; i < s.len(); i++) begin
			beat.ch  = s[i];
			beat.fin = (i == s.len() - 1);
			pending_chars.push_back(beat);
		end
	endfunction

	// Mostly back to back, some short gaps, a few long ones; none while the sink holds off.
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (hold_left > 0 || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [sitda_pkg::VALUE_BITS-1:0] random_value();
		logic [sitda_pkg::VALUE_BITS-1:0] v;
		int                               p;
		case ($urandom_range(0, 4))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 200);
			3: begin
				p = 1;
				repeat ($urandom_range(0, 9)) p = p * RADIX;
				v = p + $urandom_range(0, 2) - 1;
			end
			default: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
		endcase
		if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000)
			v = ~v + 1'b1;
		return v;
	endfunction

	task automatic send_value(input logic signed [sitda_pkg::VALUE_BITS-1:0] v,
		input string txt);
		repeat (sender_gap()) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		value      <= v;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (txt.len() != 0)
			expect_text(txt);
		else
			predict_decimal(v);
		items_accepted++;
		if (v[sitda_pkg::VALUE_BITS-1])
			negatives++;
	endtask

	// Sink: random stalls, stall-free stretches, and one long hold-off.
	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_accepted >= PRESSURE_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				char_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				char_ready <= 1'b0;
			end else begin
				char_ready <= 1'b1;
				if (free_left > 0)
					free_left--;
				else if ($urandom_range(0, 19) == 0)
					free_left = $urandom_range(20, 80);
				else if ($urandom_range(0, 2) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	// Character beat checker.
	always @(posedge clk) begin
		char_beat_t exp_beat;
		if (arst_n && char_valid && char_ready) begin
			run_len++;
			if (last) begin
				if (run_len > longest_run)
					longest_run = run_len;
				run_len = 0;
			end
			if (pending_chars.size() == 0) begin
				$error("character: unexpected beat, got %0d", character);
				failures++;
			end else begin
				exp_beat = pending_chars.pop_front();
				chars_checked++;
				if (character !== exp_beat.ch) begin
					$error("character: expected %0d, got %0d", exp_beat.ch, character);
					failures++;
				end
				if (last !== exp_beat.fin) begin
					$error("last: expected %0b, got %0b", exp_beat.fin, last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles,
				pending_chars.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_value(dir_value[i], dir_text[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_value(random_value(), "");
		@(negedge clk);
		item_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d numbers (%0d negative), %0d characters, longest run %0d",
			items_accepted, negatives, chars_checked, longest_run);
		$display("with one %0d-cycle sink hold-off and random stalls on both sides",
			HOLD_CYCLES);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_conv.sv
hw/rtl/sitda_emit.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
hw/rtl/sitda_checker.sv
tb/sv/tb_signed_int_to_decimal_ascii_unit.sv
